### rtl/core/dmm_pkg.sv
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types and constants of the DNA multi-motif matcher.
// ----------------------------------------------------------------------------
`default_nettype none
package dmm_pkg;
	localparam int NUM_NODES_DEF    = 1024;
	localparam int NUM_PATTERNS_DEF = 64;
	localparam int COUNT_BITS_DEF   = 32;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_BUILD  = 2'd1,
		FUNC_SCAN   = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_PHASE = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	// base code plus valid flag
	typedef struct packed {
		logic       ok;
		logic [1:0] code;
	} base_t;

	function automatic base_t base_of(input logic [7:0] ch);
		base_t r;
		r.ok = 1'b1;
		unique case (ch)
			8'h41, 8'h61: r.code = 2'd0;
			8'h43, 8'h63: r.code = 2'd1;
			8'h47, 8'h67: r.code = 2'd2;
			8'h54, 8'h74: r.code = 2'd3;
			default: begin
				r.code = 2'd0;
				r.ok   = 1'b0;
			end
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

### rtl/core/dmm_ram.sv
// ----------------------------------------------------------------------------
// dmm_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module dmm_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

### rtl/core/dna_multi_motif_matcher.sv
// Insert and scan items pass S_RD (read goto), S_EX (step), S_MR (read mask)
// and S_FIN (result and end-mark write), which loads the result register.
// No new item is taken before the last is done: s_tready is low while an item
// is in flight or a result waits. Build runs S_BV and S_BF per queued node,
// then S_BG, S_BVIA, S_BU and S_BM per base. After reset the tables are
// cleared by a sweep while s_tready is low; arst_n clears FSM and counters.
`default_nettype none
module dna_multi_motif_matcher
	import dmm_pkg::*;
#(
	parameter int NUM_NODES    = NUM_NODES_DEF,
	parameter int NUM_PATTERNS = NUM_PATTERNS_DEF,
	parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// char_code[7:0], pattern_index[13:8], pattern_end[14], zero[15]
	input  wire logic [15:0]  s_tdata,
	// func[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// match[0], match_mask[64:1], match_total[96:65], skipped[97],
	// current_node[107:98], status[109:108], zero[111:110]
	output logic [111:0]      m_tdata
);
	localparam int NB = $clog2(NUM_NODES);
	localparam int GB = NB + 2;
	localparam int GW = NB + 1;  // valid + node

	typedef enum logic [11:0] {
		S_CLR  = 12'b000000000001,
		S_IDLE = 12'b000000000010,
		S_RD   = 12'b000000000100,
		S_EX   = 12'b000000001000,
		S_MR   = 12'b000000010000,
		S_FIN  = 12'b000000100000,
		S_BV   = 12'b000001000000, // pop queue entry
		S_BF   = 12'b000010000000, // read fail_link[v]
		S_BG   = 12'b000100000000, // read goto[v,b]
		S_BVIA = 12'b001000000000, // read goto[fv,b]
		S_BU   = 12'b010000000000, // write goto or fail, read out[u]
		S_BM   = 12'b100000000000  // read out[via], push u
	} state_t;

	state_t st_q;
	logic [GB-1:0] g_addr;  logic g_we; logic [GW-1:0] g_wd, g_rd;
	logic [NB-1:0] f_addr;  logic f_we; logic [NB-1:0] f_wd, f_rd;
	logic [NB-1:0] o_addr;  logic o_we; logic [NUM_PATTERNS-1:0] o_wd, o_rd;
	logic [NB-1:0] q_addr;  logic q_we; logic [NB-1:0] q_wd, q_rd;

	dmm_ram #(.DEPTH(NUM_NODES*4), .WIDTH(GW)) u_goto (.clk, .we(g_we), .addr(g_addr),
		.wdata(g_wd), .rdata(g_rd));
	dmm_ram #(.DEPTH(NUM_NODES), .WIDTH(NB)) u_fail (.clk, .we(f_we), .addr(f_addr),
		.wdata(f_wd), .rdata(f_rd));
	dmm_ram #(.DEPTH(NUM_NODES), .WIDTH(NUM_PATTERNS)) u_out (.clk, .we(o_we),
		.addr(o_addr), .wdata(o_wd), .rdata(o_rd));
	dmm_ram #(.DEPTH(NUM_NODES), .WIDTH(NB)) u_queue (.clk, .we(q_we), .addr(q_addr),
		.wdata(q_wd), .rdata(q_rd));

	logic [GB:0]   clr_q;
	func_t         func_q;
	base_t         base_q;
	logic [5:0]    pidx_q;
	logic          pend_q;
	logic [NB:0]   used_q;
	logic [NB-1:0] cur_q, scan_q, nxt_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic          built_q;
	logic [NB:0]   head_q, tail_q;
	logic [NB-1:0] v_q, fv_q, u_q, via_q;
	logic [1:0]    b_q;
	logic          hit_q, root_q;
	logic          mark_q;
	logic [111:0]  res_q;
	logic          mval_q;
	logic [NUM_PATTERNS-1:0] umask_q;
	logic                    merge_q;
	logic [NB-1:0]           via_c;

	logic take, out_free;
	assign out_free = !mval_q || m_tready;
	assign s_tready = (st_q == S_IDLE) && out_free;
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = mval_q;
	assign m_tdata  = res_q;

	// root children always fail to the root
	assign via_c = root_q ? '0 : g_rd[NB-1:0];

	logic [NUM_PATTERNS-1:0] pbit;
	always_comb begin
		pbit = '0;
		if ({26'd0, pidx_q} < NUM_PATTERNS) begin
			pbit = NUM_PATTERNS'(1) << pidx_q;
		end
	end

	// memory port control
	always_comb begin
		g_we = 1'b0; g_addr = {cur_q, base_q.code}; g_wd = '0;
		f_we = 1'b0; f_addr = v_q; f_wd = '0;
		o_we = 1'b0; o_addr = cur_q; o_wd = '0;
		q_we = 1'b0; q_addr = head_q[NB-1:0]; q_wd = u_q;
		unique case (st_q)
			S_CLR: begin
				g_we = 1'b1; g_addr = clr_q[GB-1:0];
				f_we = !(|clr_q[1:0]); f_addr = clr_q[GB-1:2];
				o_we = !(|clr_q[1:0]); o_addr = clr_q[GB-1:2];
			end
			S_IDLE, S_RD: begin
				g_addr = {(func_q == FUNC_SCAN) ? scan_q : cur_q, base_q.code};
			end
			S_EX: begin
				// insert: allocate new node
				if (func_q == FUNC_INSERT && !built_q && base_q.ok && !g_rd[NB]
					&& used_q < NUM_NODES) begin
					g_we = 1'b1; g_wd = {1'b1, used_q[NB-1:0]};
				end
			end
			S_MR: o_addr = nxt_q;
			S_FIN: begin
				o_addr = nxt_q;
				if (mark_q) begin
					o_we = 1'b1; o_wd = o_rd | pbit;
				end
			end
			S_BV: ;
			S_BF: f_addr = q_rd;
			S_BG: g_addr = {v_q, b_q};
			S_BVIA: g_addr = {fv_q, b_q};
			S_BU: begin
				o_addr = u_q;
				if (!hit_q) begin
					g_we = 1'b1; g_addr = {v_q, b_q}; g_wd = {1'b1, via_c};
				end else begin
					f_we = 1'b1; f_addr = u_q; f_wd = via_c;
				end
			end
			S_BM: begin
				o_addr = via_q;
				q_we = hit_q && (tail_q < NUM_NODES); q_addr = tail_q[NB-1:0];
			end
			default: ;
		endcase
		// out[u] |= out[via], in the cycle after out[via] is read
		if (merge_q) begin
			o_we = 1'b1; o_addr = u_q; o_wd = umask_q | o_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; clr_q <= '0; used_q <= (NB+1)'(1); cur_q <= '0; scan_q <= '0;
			cnt_q <= '0; built_q <= 1'b0; mval_q <= 1'b0; head_q <= '0; tail_q <= '0;
			merge_q <= 1'b0; mark_q <= 1'b0;
		end else begin
			if (m_tready && st_q != S_FIN) mval_q <= 1'b0;
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (NUM_NODES*4 - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (take) st_q <= S_RD;
				S_RD: st_q <= (func_q == FUNC_BUILD && !built_q) ? S_BG : S_EX;
				S_EX: st_q <= S_MR;
				S_MR: st_q <= S_FIN;
				S_FIN: st_q <= S_IDLE;
				default: ;
			endcase
			if (take) begin
				func_q <= func_t'(s_tuser);
				base_q <= base_of(s_tdata[7:0]);
				pidx_q <= s_tdata[13:8];
				pend_q <= s_tdata[14];
			end
			merge_q <= (st_q == S_BM) && hit_q && !root_q;
			unique case (st_q)
				S_RD: begin
					if (func_q == FUNC_BUILD && !built_q) begin
						// root level: walk bases 0..3 of root
						v_q <= '0; fv_q <= '0; b_q <= 2'd0; head_q <= '0; tail_q <= '0;
						root_q <= 1'b1;
					end
				end
				S_EX: begin
					mark_q <= 1'b0;
					nxt_q  <= cur_q;
					if (func_q == FUNC_INSERT && !built_q) begin
						if (!base_q.ok) begin
							mark_q <= pend_q;
						end else if (g_rd[NB]) begin
							nxt_q <= g_rd[NB-1:0]; mark_q <= pend_q;
						end else if (used_q < NUM_NODES) begin
							nxt_q <= used_q[NB-1:0]; mark_q <= pend_q;
							used_q <= used_q + 1'b1;
						end
					end else if (func_q == FUNC_SCAN && built_q && base_q.ok) begin
						nxt_q <= g_rd[NB] ? g_rd[NB-1:0] : '0;
					end
				end
				S_MR: ;
				S_FIN: begin
					// o_rd now = out[nxt] (read in S_MR)
					logic [NUM_PATTERNS-1:0] m;
					logic [63:0] mm;
					logic [COUNT_BITS-1:0] c;
					logic [NB-1:0] node;
					logic [1:0] stt;
					logic mt, sk;
					m = o_rd; mm = '0; c = cnt_q; mt = 1'b0; sk = 1'b0;
					stt = ST_OK; node = scan_q;
					if (func_q == FUNC_INSERT && !built_q) begin
						sk = !base_q.ok;
						if (base_q.ok && !g_rd[NB] && used_q == NUM_NODES
							&& nxt_q == cur_q && !mark_q) stt = ST_FULL;
						node = (pend_q) ? '0 : nxt_q;
						cur_q <= node;
					end else if (func_q == FUNC_BUILD && !built_q) begin
						node = '0;
						built_q <= 1'b1;
					end else if (func_q == FUNC_SCAN && built_q) begin
						sk = !base_q.ok;
						if (base_q.ok) begin
							node = nxt_q; scan_q <= nxt_q;
							mm[NUM_PATTERNS-1:0] = m;
							if (|m) begin
								mt = 1'b1;
								if (~&cnt_q) c = cnt_q + 1'b1;
							end
						end
					end else begin
						stt = ST_PHASE;
					end
					cnt_q <= c;
					res_q <= {2'b00, stt, 10'(node), sk, 32'(c), mm, mt};
					mval_q <= 1'b1;
				end
				S_BG: begin
					fv_q <= f_rd;
					st_q <= S_BVIA;
				end
				S_BVIA: begin
					hit_q <= g_rd[NB]; u_q <= g_rd[NB-1:0];
					st_q <= S_BU;
				end
				S_BU: begin
					via_q <= via_c;
					st_q <= S_BM;
				end
				S_BM: begin
					umask_q <= o_rd;
					if (hit_q) begin
						if (tail_q < NUM_NODES) tail_q <= tail_q + 1'b1;
					end
					b_q <= b_q + 1'b1;
					if (b_q == 2'd3) st_q <= S_BV;
					else st_q <= S_BG;
				end
				S_BV: begin
					root_q <= 1'b0;
					if (head_q < tail_q) begin
						head_q <= head_q + 1'b1;
						st_q <= S_BF;
					end else begin
						scan_q <= '0; mark_q <= 1'b0;
						func_q <= FUNC_BUILD; st_q <= S_MR;
					end
				end
				S_BF: begin
					v_q <= q_rd; b_q <= 2'd0;
					st_q <= S_BG;
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) take |=> st_q == S_RD)
		else $error("item not started");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FIN) |=> m_tvalid) else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_CLR) |-> !s_tready) else $error("accept during clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(built_q) |-> scan_q == '0) else $error("build state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while waiting");
endmodule
`default_nettype wire

### dv/dmm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_checker
// Watches both stream channels of the motif matcher, keeps its own copy of
// the automaton, and compares every result transfer with the oldest
// expectation.
// ----------------------------------------------------------------------------
module dmm_checker
	import dmm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [15:0]  s_tdata,
	input  wire logic [1:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [111:0] m_tdata,
	output int                errors,
	output int                pending
);
	localparam int NODES = NUM_NODES_DEF;

	typedef struct packed {
		logic        match;
		logic [63:0] mask;
		logic [31:0] total;
		logic        skipped;
		logic [9:0]  node;
		status_t     status;
	} scan_result_t;

	scan_result_t result_fifo[$];

	logic [9:0]  next_node[NODES*4];
	bit          edge_ok[NODES*4];
	logic [9:0]  fail_to[NODES];
	logic [63:0] pat_mask[NODES];
	logic [9:0]  walk_q[NODES];
	int          used_cnt;
	logic [9:0]  cursor;
	logic [9:0]  text_node;
	logic [31:0] hit_count;
	bit          is_built;

	assign pending = result_fifo.size();

	function automatic int dna_code(input logic [7:0] ch);
		case (ch)
			"A", "a": return 0;
			"C", "c": return 1;
			"G", "g": return 2;
			"T", "t": return 3;
			default:  return -1;
		endcase
	endfunction

	task automatic close_pattern(input logic [5:0] idx);
		pat_mask[cursor] = pat_mask[cursor] | (64'd1 << idx);
		cursor = '0;
	endtask

	// breadth-first pass: completes goto edges and merges masks along fail links
	task automatic link_automaton();
		int head, tail, v, fv, slot, via, u;
		head = 0;
		tail = 0;
		for (int b = 0; b < 4; b++) begin
			if (edge_ok[b]) begin
				fail_to[next_node[b]] = '0;
				if (tail < NODES) begin
					walk_q[tail] = next_node[b];
					tail++;
				end
			end else begin
				next_node[b] = '0;
				edge_ok[b]   = 1'b1;
			end
		end
		while (head < tail) begin
			v = walk_q[head];
			head++;
			fv = fail_to[v];
			for (int b = 0; b < 4; b++) begin
				slot = v*4 + b;
				via  = next_node[fv*4 + b];
				if (!edge_ok[slot]) begin
					next_node[slot] = via;
					edge_ok[slot]   = 1'b1;
				end else begin
					u = next_node[slot];
					fail_to[u]  = via;
					pat_mask[u] = pat_mask[u] | pat_mask[via];
					if (tail < NODES) begin
						walk_q[tail] = u;
						tail++;
					end
				end
			end
		end
	endtask

	task automatic predict_item(input func_t f, input logic [15:0] d);
		scan_result_t r;
		int b, slot;
		logic        pend;
		logic [5:0]  idx;
		b    = dna_code(d[7:0]);
		idx  = d[13:8];
		pend = d[14];
		r = '0;
		r.status = ST_OK;
		if (f == FUNC_INSERT && !is_built) begin
			if (b < 0) begin
				r.skipped = 1'b1;
				if (pend) close_pattern(idx);
			end else begin
				slot = cursor*4 + b;
				if (edge_ok[slot]) begin
					cursor = next_node[slot];
					if (pend) close_pattern(idx);
				end else if (used_cnt >= NODES) begin
					r.status = ST_FULL;
					if (pend) cursor = '0;
				end else begin
					next_node[slot] = used_cnt[9:0];
					edge_ok[slot]   = 1'b1;
					cursor          = used_cnt[9:0];
					used_cnt++;
					if (pend) close_pattern(idx);
				end
			end
			r.node = cursor;
		end else if (f == FUNC_BUILD && !is_built) begin
			link_automaton();
			is_built  = 1'b1;
			text_node = '0;
			r.node    = text_node;
		end else if (f == FUNC_SCAN && is_built) begin
			if (b < 0) begin
				r.skipped = 1'b1;
			end else begin
				slot = text_node*4 + b;
				text_node = edge_ok[slot] ? next_node[slot] : '0;
				r.mask = pat_mask[text_node];
				if (r.mask != 0) begin
					r.match = 1'b1;
					if (hit_count != '1) hit_count++;
				end
			end
			r.node = text_node;
		end else begin
			r.status = ST_PHASE;
			r.node   = text_node;
		end
		r.total = hit_count;
		result_fifo.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_result_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < NODES*4; i++) begin
				next_node[i] = '0;
				edge_ok[i]   = 1'b0;
			end
			for (int i = 0; i < NODES; i++) begin
				fail_to[i]  = '0;
				pat_mask[i] = '0;
			end
			used_cnt  = 1;
			cursor    = '0;
			text_node = '0;
			hit_count = '0;
			is_built  = 1'b0;
			errors    = 0;
			result_fifo.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0], m_tdata[64:1], m_tdata[96:65], m_tdata[97],
					m_tdata[107:98], status_t'(m_tdata[109:108])};
				if (result_fifo.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transfer %h", $time, got);
				end else begin
					want = result_fifo.pop_front();
					if (got.match !== want.match || got.mask !== want.mask ||
							got.total !== want.total || got.skipped !== want.skipped ||
							got.node !== want.node || got.status !== want.status) begin
						errors++;
						$display("%0t: mismatch expected match=%b mask=%h total=%0d skip=%b node=%0d st=%0d",
							$time, want.match, want.mask, want.total, want.skipped,
							want.node, want.status);
						$display("%0t:          actual   match=%b mask=%h total=%0d skip=%b node=%0d st=%0d",
							$time, got.match, got.mask, got.total, got.skipped,
							got.node, got.status);
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_item(func_t'(s_tuser), s_tdata);
		end
	end
endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the DNA motif matcher: pattern inserts up to a full state
// table, the failure-link build, then text scans, under random idling.
// ----------------------------------------------------------------------------
module tb_top;
	import dmm_pkg::*;

	localparam int LIMIT = 600000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tdata = '0;
	logic [1:0]   s_tuser = FUNC_INSERT;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;
	int           errors, pending;
	int           tx_idle = 37, rx_idle = 73;
	int           sent = 0;
	int           cycles = 0;
	bit           rx_hold = 1'b0;
	bit           scan_phase = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	dna_multi_motif_matcher u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	dmm_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_idle);

	// long receiver stall once scanning starts, so the block backs up
	initial begin
		wait (scan_phase);
		rx_hold = 1'b1;
		repeat (400) @(posedge clk);
		rx_hold = 1'b0;
	end

	task automatic send_item(input func_t f, input logic [7:0] ch,
			input logic [5:0] idx, input logic pend);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {1'b0, pend, idx, ch};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent++;
		if (sent == 400) begin
			tx_idle = 73;
			rx_idle = 37;
		end else if (sent == 800) begin
			tx_idle = 0;
			rx_idle = 0;
		end
	endtask

	function automatic logic [7:0] rand_base();
		logic [7:0] up;
		case ($urandom_range(3))
			0: up = "A";
			1: up = "C";
			2: up = "G";
			default: up = "T";
		endcase
		return $urandom_range(1) ? up : (up | 8'h20);
	endfunction

	function automatic logic [7:0] rand_char(input int base_pct);
		return ($urandom_range(99) < base_pct) ? rand_base() : 8'($urandom_range(255));
	endfunction

	initial begin
		int inserts, len;
		logic pend_last;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wrong-phase items before the build
		send_item(FUNC_SCAN, "A", 6'd0, 1'b0);
		send_item(FUNC_NONE, "C", 6'd63, 1'b1);
		// short patterns, both cases, index extremes
		send_item(FUNC_INSERT, "A", 6'd0, 1'b0);
		send_item(FUNC_INSERT, "C", 6'd0, 1'b0);
		send_item(FUNC_INSERT, "G", 6'd0, 1'b1);
		send_item(FUNC_INSERT, "c", 6'd63, 1'b0);
		send_item(FUNC_INSERT, "g", 6'd63, 1'b1);
		send_item(FUNC_INSERT, "t", 6'd5, 1'b0);
		send_item(FUNC_INSERT, "a", 6'd5, 1'b1);
		// non-base in a pattern, then non-base carrying the end mark
		send_item(FUNC_INSERT, "T", 6'd9, 1'b0);
		send_item(FUNC_INSERT, "N", 6'd9, 1'b0);
		send_item(FUNC_INSERT, 8'hFF, 6'd9, 1'b0);
		send_item(FUNC_INSERT, "T", 6'd9, 1'b0);
		send_item(FUNC_INSERT, 8'h00, 6'd42, 1'b1);
		// existing prefix reused, end mark on an inner node
		send_item(FUNC_INSERT, "A", 6'd21, 1'b0);
		send_item(FUNC_INSERT, "C", 6'd21, 1'b1);

		// long random patterns until the state table runs out
		inserts = 0;
		while (inserts < 1070) begin
			len = $urandom_range(40, 80);
			pend_last = ($urandom_range(9) != 0);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 1)
					send_item(func_t'($urandom_range(2) == 0 ? FUNC_NONE : FUNC_SCAN),
						rand_char(50), 6'($urandom_range(63)), 1'($urandom_range(1)));
				send_item(FUNC_INSERT, rand_char(99), 6'($urandom_range(63)),
					(i == len-1) && pend_last);
				inserts++;
			end
		end

		send_item(FUNC_BUILD, 8'($urandom_range(255)), 6'($urandom_range(63)), 1'b0);
		send_item(FUNC_BUILD, "A", 6'd0, 1'b1);
		send_item(FUNC_INSERT, "G", 6'd3, 1'b1);
		send_item(FUNC_NONE, "T", 6'd0, 1'b0);
		scan_phase = 1'b1;
		send_item(FUNC_SCAN, "A", 6'd0, 1'b0);
		send_item(FUNC_SCAN, "c", 6'd0, 1'b0);
		send_item(FUNC_SCAN, "*", 6'd0, 1'b0);
		send_item(FUNC_SCAN, "G", 6'd0, 1'b0);

		for (int i = 0; i < 60; i++) begin
			if ($urandom_range(99) < 4)
				send_item(func_t'($urandom_range(3)), rand_char(50),
					6'($urandom_range(63)), 1'($urandom_range(1)));
			else
				send_item(FUNC_SCAN, rand_char(88), 6'($urandom_range(63)),
					1'($urandom_range(1)));
		end
		s_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

### sim.f
rtl/core/dmm_pkg.sv
rtl/core/dmm_ram.sv
rtl/core/dna_multi_motif_matcher.sv
dv/dmm_checker.sv
dv/tb_top.sv
